// File: hw/rtl/hpa_pkg.sv
package hpa_pkg;

  localparam int QW = 11;
  localparam int HUE_W = 13;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 11;

  localparam logic [HUE_W-1:0] HUE_FULL = 13'd6144;
  localparam logic [10:0] SAT_ONE = 11'd1024;
  localparam logic [7:0] CHAN_MAX = 8'd255;

  // Exact floor(d * 1024 / 60) for d below 512: (d * ANGLE_RECIP) >> ANGLE_SHIFT.
  localparam logic [17:0] ANGLE_RECIP = 18'd139811;
  localparam int ANGLE_SHIFT = 13;

  localparam logic [1:0] MODE_KEEP = 2'd0;
  localparam logic [1:0] MODE_ABS = 2'd1;
  localparam logic [1:0] MODE_REL = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_HUE_MODE = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_MODE = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_VAL_MODE = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_HUE_DEGREES = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_AMOUNT = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_VAL_AMOUNT = 3'd5;

  localparam logic [1:0] SECT_RED = 2'd0;
  localparam logic [1:0] SECT_GREEN = 2'd1;
  localparam logic [1:0] SECT_BLUE = 2'd2;

  typedef struct packed {
    logic [1:0]  hue_mode;
    logic [1:0]  sat_mode;
    logic [1:0]  val_mode;
    logic [8:0]  hue_degrees;
    logic [10:0] sat_amount;
    logic [10:0] val_amount;
  } cfg_t;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [7:0] vmax;
    logic [7:0] delta;
    logic [7:0] adiff;
    logic [1:0] sect;
    logic       neg;
  } pix_t;

  // One restoring division step: returns {quotient bit, new remainder}.
  function automatic logic [8:0] div_step(input logic [8:0] x, input logic [7:0] d);
    logic       ge;
    logic [8:0] diff;
    ge = (x >= {1'b0, d});
    diff = x - {1'b0, d};
    return {ge, ge ? diff[7:0] : x[7:0]};
  endfunction

endpackage

// File: hw/rtl/hpa_if.sv
interface hpa_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_in;
  logic [7:0] green_in;
  logic [7:0] blue_in;
  modport source(output valid, output red_in, output green_in, output blue_in, input ready);
  modport sink(input valid, input red_in, input green_in, input blue_in, output ready);
endinterface

interface hpa_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] red_out;
  logic [7:0] green_out;
  logic [7:0] blue_out;
  logic       recolored;
  modport source(output valid, output red_out, output green_out, output blue_out,
                 output recolored, input ready);
  modport sink(input valid, input red_out, input green_out, input blue_out,
               input recolored, output ready);
endinterface

// File: hw/rtl/hsv_pixel_adjust.sv
// Per-pixel HSV adjuster: each RGB word is converted to hue (1024 per 60
// degrees), saturation (over 1024) and value, adjusted by the mode registers,
// and converted back by hue sector. A new word is taken on every clock unless
// the pipe stalls; the pipe holds 16 register stages: the front, the two
// 11-stage bit-per-cycle dividers side by side, three back-end stages and the
// output register. The whole pipe stalls only while the output word is held
// and not taken. The user must see that configuration registers are written
// only while the pipe is empty; the block itself does not enforce this. They
// apply to every word accepted afterwards.
module hsv_pixel_adjust (
  input  logic                              clk,
  input  logic                              rst,
  hpa_in_if.sink                            pix_in,
  hpa_out_if.source                         pix_out,
  input  logic                              cfg_we,
  input  logic [hpa_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [hpa_pkg::CFG_DATA_W-1:0]    cfg_data
);

  hpa_pkg::cfg_t cfg;
  logic          adv;
  logic          f_valid;
  hpa_pkg::pix_t f_pix;
  logic          d_valid;
  hpa_pkg::pix_t d_pix;
  logic [hpa_pkg::QW-1:0] sat_q;
  logic [hpa_pkg::QW-1:0] hue_q;

  assign adv = !pix_out.valid || pix_out.ready;
  assign pix_in.ready = adv;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.hue_mode <= hpa_pkg::MODE_ABS;
      cfg.sat_mode <= hpa_pkg::MODE_KEEP;
      cfg.val_mode <= hpa_pkg::MODE_KEEP;
      cfg.hue_degrees <= '0;
      cfg.sat_amount <= '0;
      cfg.val_amount <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hpa_pkg::REG_HUE_MODE:    cfg.hue_mode <= cfg_data[1:0];
        hpa_pkg::REG_SAT_MODE:    cfg.sat_mode <= cfg_data[1:0];
        hpa_pkg::REG_VAL_MODE:    cfg.val_mode <= cfg_data[1:0];
        hpa_pkg::REG_HUE_DEGREES: cfg.hue_degrees <= cfg_data[8:0];
        hpa_pkg::REG_SAT_AMOUNT:  cfg.sat_amount <= cfg_data;
        hpa_pkg::REG_VAL_AMOUNT:  cfg.val_amount <= cfg_data;
        default: ;
      endcase
    end
  end

  hpa_front u_front (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (pix_in.valid),
    .red       (pix_in.red_in),
    .green     (pix_in.green_in),
    .blue      (pix_in.blue_in),
    .out_valid (f_valid),
    .out_pix   (f_pix)
  );

  hpa_div u_div (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .in_valid  (f_valid),
    .in_pix    (f_pix),
    .out_valid (d_valid),
    .out_pix   (d_pix),
    .sat_q     (sat_q),
    .hue_q     (hue_q)
  );

  hpa_back u_back (
    .clk      (clk),
    .rst      (rst),
    .adv      (adv),
    .cfg      (cfg),
    .in_valid (d_valid),
    .in_pix   (d_pix),
    .sat_q    (sat_q),
    .hue_q    (hue_q),
    .pix_out  (pix_out)
  );

endmodule

// File: hw/rtl/hpa_front.sv
module hpa_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          adv,
  input  logic          in_valid,
  input  logic [7:0]    red,
  input  logic [7:0]    green,
  input  logic [7:0]    blue,
  output logic          out_valid,
  output hpa_pkg::pix_t out_pix
);

  hpa_pkg::pix_t pix_next;
  logic [7:0] mx;
  logic [7:0] mn;
  logic [8:0] diff;

  always_comb begin
    mx = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    mn = red;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;
    // Ties go to red first, then green.
    priority if (red == mx) begin
      diff = {1'b0, green} - {1'b0, blue};
      pix_next.sect = hpa_pkg::SECT_RED;
    end else if (green == mx) begin
      diff = {1'b0, blue} - {1'b0, red};
      pix_next.sect = hpa_pkg::SECT_GREEN;
    end else begin
      diff = {1'b0, red} - {1'b0, green};
      pix_next.sect = hpa_pkg::SECT_BLUE;
    end
    pix_next.red = red;
    pix_next.green = green;
    pix_next.blue = blue;
    pix_next.vmax = mx;
    pix_next.delta = mx - mn;
    pix_next.neg = diff[8];
    pix_next.adiff = diff[8] ? 8'(-diff) : diff[7:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pix <= pix_next;
    end
  end

endmodule

// File: hw/rtl/hpa_div.sv
module hpa_div (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  logic                   in_valid,
  input  hpa_pkg::pix_t          in_pix,
  output logic                   out_valid,
  output hpa_pkg::pix_t          out_pix,
  output logic [hpa_pkg::QW-1:0] sat_q,
  output logic [hpa_pkg::QW-1:0] hue_q
);

  localparam int QW = hpa_pkg::QW;

  // Two restoring dividers side by side, one quotient bit per stage:
  // delta*1024/max for saturation and |diff|*1024/delta for hue.
  logic [QW-1:0]  vld;
  hpa_pkg::pix_t  info [QW];
  logic [7:0]     rs [QW];
  logic [7:0]     rh [QW];
  logic [QW-1:0]  qs [QW];
  logic [QW-1:0]  qh [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [8:0]    xs;
    logic [8:0]    xh;
    logic [8:0]    ss;
    logic [8:0]    sh;
    logic          vin;
    hpa_pkg::pix_t pin;
    logic [QW-1:0] qs_in;
    logic [QW-1:0] qh_in;

    if (k == 0) begin : g_first
      assign vin = in_valid;
      assign pin = in_pix;
      assign xs = {1'b0, in_pix.delta};
      assign xh = {1'b0, in_pix.adiff};
      assign qs_in = '0;
      assign qh_in = '0;
    end else begin : g_rest
      assign vin = vld[k-1];
      assign pin = info[k-1];
      assign xs = {rs[k-1], 1'b0};
      assign xh = {rh[k-1], 1'b0};
      assign qs_in = qs[k-1];
      assign qh_in = qh[k-1];
    end

    assign ss = hpa_pkg::div_step(xs, pin.vmax);
    assign sh = hpa_pkg::div_step(xh, pin.delta);

    always_ff @(posedge clk) begin
      if (rst) begin
        vld[k] <= 1'b0;
      end else if (adv) begin
        vld[k] <= vin;
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        info[k] <= pin;
        rs[k] <= ss[7:0];
        rh[k] <= sh[7:0];
        qs[k] <= {qs_in[QW-2:0], ss[8]};
        qh[k] <= {qh_in[QW-2:0], sh[8]};
      end
    end
  end

  assign out_valid = vld[QW-1];
  assign out_pix = info[QW-1];
  assign sat_q = qs[QW-1];
  assign hue_q = qh[QW-1];

endmodule

// File: hw/rtl/hpa_back.sv
module hpa_back (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   adv,
  input  hpa_pkg::cfg_t          cfg,
  input  logic                   in_valid,
  input  hpa_pkg::pix_t          in_pix,
  input  logic [hpa_pkg::QW-1:0] sat_q,
  input  logic [hpa_pkg::QW-1:0] hue_q,
  hpa_out_if.source              pix_out
);

  localparam int HW = hpa_pkg::HUE_W;

  // Target or rotation angle, derived from the configuration.
  logic [HW-1:0] angle;
  logic [26:0]   angle_prod;
  logic [13:0]   angle_raw;

  always_comb begin
    angle_prod = 27'(cfg.hue_degrees) * 27'(hpa_pkg::ANGLE_RECIP);
    angle_raw = angle_prod[hpa_pkg::ANGLE_SHIFT +: 14];
  end

  always_ff @(posedge clk) begin
    angle <= (angle_raw >= {1'b0, hpa_pkg::HUE_FULL}) ?
             HW'(angle_raw - {1'b0, hpa_pkg::HUE_FULL}) : angle_raw[HW-1:0];
  end

  // Stage 1: hue assembly, mode selection and relative scaling.
  logic [10:0]   sq;
  logic [13:0]   hbase;
  logic [13:0]   hadd;
  logic [HW-1:0] h;
  logic [13:0]   hsum;
  logic [HW-1:0] hu_next;
  logic [21:0]   sprod;
  logic [13:0]   s_next;
  logic [18:0]   vprod;
  logic [10:0]   v_next;
  logic          pass_next;

  always_comb begin
    sq = (in_pix.delta == 8'd0) ? 11'd0 : sat_q;
    unique case (in_pix.sect)
      hpa_pkg::SECT_GREEN: hbase = 14'd2048;
      hpa_pkg::SECT_BLUE:  hbase = 14'd4096;
      default:             hbase = 14'd0;
    endcase
    hadd = in_pix.neg ? hbase - 14'(hue_q) : hbase + 14'(hue_q);
    if (hadd[13]) hadd = hadd + 14'(hpa_pkg::HUE_FULL);
    h = (in_pix.delta == 8'd0) ? '0 : hadd[HW-1:0];

    hsum = 14'(h) + 14'(angle);
    if (hsum >= 14'(hpa_pkg::HUE_FULL)) hsum = hsum - 14'(hpa_pkg::HUE_FULL);
    priority if (cfg.hue_mode == hpa_pkg::MODE_ABS) hu_next = angle;
    else if (cfg.hue_mode == hpa_pkg::MODE_REL) hu_next = hsum[HW-1:0];
    else hu_next = h;

    sprod = 22'(sq) * 22'(cfg.sat_amount);
    priority if (cfg.sat_mode == hpa_pkg::MODE_ABS) s_next = 14'(cfg.sat_amount);
    else if (cfg.sat_mode == hpa_pkg::MODE_REL) s_next = sprod[21:8];
    else s_next = 14'(sq);

    vprod = 19'(in_pix.vmax) * 19'(cfg.val_amount);
    priority if (cfg.val_mode == hpa_pkg::MODE_ABS) v_next = cfg.val_amount;
    else if (cfg.val_mode == hpa_pkg::MODE_REL) v_next = vprod[18:8];
    else v_next = 11'(in_pix.vmax);

    pass_next = (sq == 11'd0) && (cfg.sat_mode != hpa_pkg::MODE_ABS) &&
                (cfg.sat_mode != hpa_pkg::MODE_REL);
  end

  logic          v1;
  logic [HW-1:0] hu1;
  logic [13:0]   s1;
  logic [10:0]   val1;
  logic          pass1;
  logic [23:0]   rgb1;

  // Stage 2: clamp, then the first products of the sector conversion.
  logic [10:0] s2c;
  logic [7:0]  v2c;
  logic [9:0]  f2;
  logic [18:0] pprod_next;
  logic [20:0] sf_next;
  logic [21:0] sfc_full;

  always_comb begin
    s2c = (s1 > 14'(hpa_pkg::SAT_ONE)) ? hpa_pkg::SAT_ONE : s1[10:0];
    v2c = (val1 > 11'(hpa_pkg::CHAN_MAX)) ? hpa_pkg::CHAN_MAX : val1[7:0];
    f2 = hu1[9:0];
    pprod_next = 19'(v2c) * 19'(hpa_pkg::SAT_ONE - s2c);
    sf_next = 21'(s2c) * 21'(f2);
    sfc_full = 22'(s2c) * 22'(hpa_pkg::SAT_ONE - 11'(f2));
  end

  logic        v2;
  logic [2:0]  k2;
  logic [7:0]  val2;
  logic [18:0] pprod2;
  logic [20:0] sf2;
  logic [20:0] sfc2;
  logic        pass2;
  logic [23:0] rgb2;

  // Stage 3: q and t.
  logic [28:0] qprod;
  logic [28:0] tprod;

  always_comb begin
    qprod = 29'(val2) * 29'(22'h100000 - 22'(sf2));
    tprod = 29'(val2) * 29'(22'h100000 - 22'(sfc2));
  end

  logic       v3;
  logic [2:0] k3;
  logic [7:0] val3;
  logic [7:0] p3;
  logic [7:0] q3;
  logic [7:0] t3;
  logic       pass3;
  logic [23:0] rgb3;

  // Output stage: pick the channels by sector, or pass the input word through when it is not recolored.
  logic [7:0] ro;
  logic [7:0] go;
  logic [7:0] bo;

  always_comb begin
    unique case (k3)
      3'd1: begin ro = q3; go = val3; bo = p3; end
      3'd2: begin ro = p3; go = val3; bo = t3; end
      3'd3: begin ro = p3; go = q3; bo = val3; end
      3'd4: begin ro = t3; go = p3; bo = val3; end
      3'd5: begin ro = val3; go = p3; bo = q3; end
      default: begin ro = val3; go = t3; bo = p3; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      pix_out.valid <= 1'b0;
    end else if (adv) begin
      v1 <= in_valid;
      v2 <= v1;
      v3 <= v2;
      pix_out.valid <= v3;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      hu1 <= hu_next;
      s1 <= s_next;
      val1 <= v_next;
      pass1 <= pass_next;
      rgb1 <= {in_pix.red, in_pix.green, in_pix.blue};

      k2 <= hu1[HW-1:10];
      val2 <= v2c;
      pprod2 <= pprod_next;
      sf2 <= sf_next;
      sfc2 <= sfc_full[20:0];
      pass2 <= pass1;
      rgb2 <= rgb1;

      k3 <= k2;
      val3 <= val2;
      p3 <= pprod2[17:10];
      q3 <= qprod[27:20];
      t3 <= tprod[27:20];
      pass3 <= pass2;
      rgb3 <= rgb2;

      pix_out.red_out <= pass3 ? rgb3[23:16] : ro;
      pix_out.green_out <= pass3 ? rgb3[15:8] : go;
      pix_out.blue_out <= pass3 ? rgb3[7:0] : bo;
      pix_out.recolored <= !pass3;
    end
  end

endmodule

// File: hw/rtl/hpa_checker.sv
module hpa_checker (
  input logic       clk,
  input logic       rst,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] red_out,
  input logic [7:0] green_out,
  input logic [7:0] blue_out,
  input logic       recolored
);

  // Reset empties the pipe, so no word may show right after it.
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("output word valid after reset");

  // The input side stalls exactly when a finished word is held.
  a_ready: assert property (@(posedge clk) disable iff (rst)
    in_ready == (!out_valid || out_ready))
    else $error("input ready does not follow output backpressure");

  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(red_out) && $stable(green_out)
      && $stable(blue_out) && $stable(recolored))
    else $error("stalled output word changed");

endmodule

bind hsv_pixel_adjust hpa_checker u_hpa_checker (
  .clk       (clk),
  .rst       (rst),
  .in_ready  (pix_in.ready),
  .out_valid (pix_out.valid),
  .out_ready (pix_out.ready),
  .red_out   (pix_out.red_out),
  .green_out (pix_out.green_out),
  .blue_out  (pix_out.blue_out),
  .recolored (pix_out.recolored)
);
